FILE: design/rbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/box intersection package
// Widths, pipeline depths and item types shared by the intersection pipeline.
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int W          = 32;
    localparam int NUM_W      = W + 1 + FRAC_BITS;
    localparam int Q_BITS     = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = Q_BITS / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 1;
    localparam int REM_W      = W + 1;
    localparam int T_W        = 31;
    localparam int CMP_W      = W + T_W + 1;
    localparam int PROD_W     = 2 * W;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    typedef logic signed [W-1:0] t_fx;

    typedef struct packed {
        t_fx [2:0] o;
        t_fx [2:0] d;
        t_fx [2:0] lo;
        t_fx [2:0] hi;
    } t_ray;

    typedef struct packed {
        t_ray       ray;
        logic       in_box;
        logic [2:0] act;
    } t_side;

endpackage

FILE: design/rbi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Restoring division, four quotient bits per stage; quotients above the
// 31-bit range come out as the maximum value.
// ----------------------------------------------------------------------------
module rbi_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [rbi_pkg::NUM_W-1:0]    i_num,
    input  logic [rbi_pkg::W-1:0]        i_den,
    output logic [rbi_pkg::T_W-1:0]      o_quot
);

    logic                         r_sat [rbi_pkg::DIV_LAT];
    logic [rbi_pkg::W-1:0]        r_den [rbi_pkg::DIV_LAT];
    logic [rbi_pkg::REM_W-1:0]    r_rem [rbi_pkg::DIV_LAT];
    logic [rbi_pkg::Q_BITS-1:0]   r_low [rbi_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= {{(rbi_pkg::CMP_W - rbi_pkg::NUM_W){1'b0}}, i_num}
                        >= {1'b0, i_den, {rbi_pkg::T_W{1'b0}}};
            r_rem[0] <= rbi_pkg::REM_W'(i_num >> rbi_pkg::Q_BITS);
            r_low[0] <= i_num[rbi_pkg::Q_BITS-1:0];
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 1; k < rbi_pkg::DIV_LAT; k++) begin : g_stage
        logic [rbi_pkg::REM_W-1:0]  n_rem;
        logic [rbi_pkg::Q_BITS-1:0] n_low;

        always_comb begin
            n_rem = r_rem[k-1];
            n_low = r_low[k-1];
            for (int i = 0; i < rbi_pkg::DIV_STEP; i++) begin
                n_rem = {n_rem[rbi_pkg::REM_W-2:0], n_low[rbi_pkg::Q_BITS-1]};
                n_low = {n_low[rbi_pkg::Q_BITS-2:0], 1'b0};
                if (n_rem >= {1'b0, r_den[k-1]}) begin
                    n_rem    = n_rem - {1'b0, r_den[k-1]};
                    n_low[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[k] <= r_sat[k-1];
                r_den[k] <= r_den[k-1];
                r_rem[k] <= n_rem;
                r_low[k] <= n_low;
            end
        end
    end

    assign o_quot = r_sat[rbi_pkg::DIV_LAT-1] ? rbi_pkg::T_MAX
                  : r_low[rbi_pkg::DIV_LAT-1][rbi_pkg::T_W-1:0];

endmodule

FILE: design/ray_box_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/box intersection
// Finds whether a ray meets an axis-aligned box and the nearest hit distance.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_axis    in   12 x 32-bit Q16.16: origin xyz, dir xyz, box lo xyz, box hi xyz
// m_axis    out  hit flag, 31-bit hit distance
//
// One beat is accepted per cycle unless the output stalls; it passes entry, the
// dividers (9 stages, 4 quotient bits per step), multiply, add, compare and output.
// Reset clears all valid bits; data registers are not reset.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_intersect (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
    input  logic [383:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit, hit_distance
    output logic [31:0]  o_m_tdata
);

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    rbi_pkg::t_ray  in_ray;
    rbi_pkg::t_side n_side;
    logic [rbi_pkg::NUM_W-1:0] n_num [3];
    logic [rbi_pkg::W-1:0]     n_den [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            in_ray.o[a]  = i_s_tdata[32*a +: 32];
            in_ray.d[a]  = i_s_tdata[96 + 32*a +: 32];
            in_ray.lo[a] = i_s_tdata[192 + 32*a +: 32];
            in_ray.hi[a] = i_s_tdata[288 + 32*a +: 32];
        end
    end

    always_comb begin
        logic pos;
        logic neg;
        logic signed [32:0] diff;
        logic [32:0] dmag;
        n_side.ray    = in_ray;
        n_side.in_box = 1'b1;
        for (int a = 0; a < 3; a++) begin
            n_side.in_box = n_side.in_box
                && ($signed(in_ray.o[a]) > $signed(in_ray.lo[a]))
                && ($signed(in_ray.o[a]) < $signed(in_ray.hi[a]));
            pos = ($signed(in_ray.d[a]) > 0)
                && ($signed(in_ray.o[a]) <= $signed(in_ray.lo[a]));
            neg = ($signed(in_ray.d[a]) < 0)
                && ($signed(in_ray.o[a]) >= $signed(in_ray.hi[a]));
            n_side.act[a] = pos || neg;
            diff = pos ? $signed({in_ray.lo[a][31], in_ray.lo[a]})
                           - $signed({in_ray.o[a][31], in_ray.o[a]})
                       : $signed({in_ray.hi[a][31], in_ray.hi[a]})
                           - $signed({in_ray.o[a][31], in_ray.o[a]});
            dmag     = diff[32] ? 33'(-diff) : 33'(diff);
            n_num[a] = rbi_pkg::NUM_W'(dmag) << rbi_pkg::FRAC_BITS;
            n_den[a] = in_ray.d[a][31] ? 32'(-in_ray.d[a]) : 32'(in_ray.d[a]);
        end
    end

    logic                       r_v0;
    rbi_pkg::t_side             r_s0;
    logic [rbi_pkg::NUM_W-1:0]  r_num [3];
    logic [rbi_pkg::W-1:0]      r_den [3];
    logic                       r_sv [rbi_pkg::DIV_LAT];
    rbi_pkg::t_side             r_sd [rbi_pkg::DIV_LAT];
    logic [rbi_pkg::T_W-1:0]    quot [3];

    for (genvar a = 0; a < 3; a++) begin : g_div
        rbi_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num[a]),
            .i_den  (r_den[a]),
            .o_quot (quot[a])
        );
    end

    logic                               r_vm, r_vp, r_vc;
    rbi_pkg::t_side                     r_m, r_p, r_c;
    logic [rbi_pkg::T_W-1:0]            r_tm [3];
    logic [rbi_pkg::T_W-1:0]            r_tp [3];
    logic [rbi_pkg::T_W-1:0]            r_tc [3];
    logic signed [rbi_pkg::PROD_W-1:0]  r_prod [3][2];
    logic signed [rbi_pkg::PROD_W-1:0]  r_pt [3][2];
    logic [2:0]                         r_ok;
    logic [rbi_pkg::PROD_W-1:0]         n_prod [3][2];
    logic [rbi_pkg::PROD_W-1:0]         n_pt [3][2];
    logic [2:0]                         n_ok;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int B = (a == 0) ? 1 : 0;
        localparam int C = (a == 2) ? 1 : 2;
        localparam int AX [2] = '{B, C};
        for (genvar j = 0; j < 2; j++) begin : g_oth
            assign n_prod[a][j] = $signed(r_sd[rbi_pkg::DIV_LAT-1].ray.d[AX[j]])
                                * $signed({1'b0, quot[a]});
            assign n_pt[a][j] = $signed({{32{r_m.ray.o[AX[j]][31]}},
                                         r_m.ray.o[AX[j]]})
                              + (r_prod[a][j] >>> rbi_pkg::FRAC_BITS);
        end
        assign n_ok[a] = r_p.act[a]
            && (r_pt[a][0] >= $signed({{32{r_p.ray.lo[B][31]}}, r_p.ray.lo[B]}))
            && (r_pt[a][0] <= $signed({{32{r_p.ray.hi[B][31]}}, r_p.ray.hi[B]}))
            && (r_pt[a][1] >= $signed({{32{r_p.ray.lo[C][31]}}, r_p.ray.lo[C]}))
            && (r_pt[a][1] <= $signed({{32{r_p.ray.hi[C][31]}}, r_p.ray.hi[C]}));
    end

    logic                    n_hit;
    logic [rbi_pkg::T_W-1:0] n_dist;

    always_comb begin
        n_hit  = 1'b0;
        n_dist = '0;
        for (int a = 0; a < 3; a++) begin
            if (r_ok[a] && (!n_hit || r_tc[a] < n_dist)) begin
                n_hit  = 1'b1;
                n_dist = r_tc[a];
            end
        end
        if (r_c.in_box) begin
            n_hit  = 1'b1;
            n_dist = '0;
        end
    end

    logic [31:0] r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0  <= n_side;
            r_num <= n_num;
            r_den <= n_den;
            r_sd[0] <= r_s0;
            for (int k = 1; k < rbi_pkg::DIV_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_m  <= r_sd[rbi_pkg::DIV_LAT-1];
            r_tm <= quot;
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < 2; j++) begin
                    r_prod[a][j] <= n_prod[a][j];
                    r_pt[a][j]   <= n_pt[a][j];
                end
            end
            r_p   <= r_m;
            r_tp  <= r_tm;
            r_c   <= r_p;
            r_tc  <= r_tp;
            r_ok  <= n_ok;
            r_out <= {n_dist, n_hit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_vm       <= 1'b0;
            r_vp       <= 1'b0;
            r_vc       <= 1'b0;
            o_m_tvalid <= 1'b0;
            for (int k = 0; k < rbi_pkg::DIV_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (en) begin
            r_v0    <= i_s_tvalid;
            r_sv[0] <= r_v0;
            for (int k = 1; k < rbi_pkg::DIV_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_vm       <= r_sv[rbi_pkg::DIV_LAT-1];
            r_vp       <= r_vm;
            r_vc       <= r_vp;
            o_m_tvalid <= r_vc;
        end
    end

    assign o_m_tdata = r_out;

    ap_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[31:1] == '0)
        else $error("miss with nonzero distance");

    ap_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    ap_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vc && r_c.in_box |=> r_out[0])
        else $error("inside origin did not report a hit");

endmodule
